FILE: hdl/tkmk_pkg.sv
`default_nettype none
package tkmk_pkg;

	localparam int CFG_W    = 5;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;
	localparam logic [CFG_W-1:0] K_RESET = 5'd3;

	localparam logic [1:0] CMD_OFFER = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic REG_K_IN_USE = 1'b0;

	typedef struct packed {
		logic signed [31:0] gain;
		logic [7:0]         src_route;
		logic [7:0]         src_pos;
		logic [7:0]         dst_route;
		logic [7:0]         to_pos;
		logic [7:0]         moved_count;
		logic [2:0]         orientation;
		logic [15:0]        demand_src;
		logic [15:0]        demand_to;
	} entry_t;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] gain;
		logic [7:0]         src_route;
		logic [7:0]         src_pos;
		logic [7:0]         dst_route;
		logic [7:0]         to_pos;
		logic [7:0]         moved_count;
		logic [2:0]         orientation;
		logic [15:0]        demand_src;
		logic [15:0]        demand_to;
	} item_t;

	typedef struct packed {
		logic               accepted;
		logic [4:0]         held_count;
		logic               last_entry;
		logic signed [31:0] out_gain;
		logic [7:0]         out_src_route;
		logic [7:0]         out_src_pos;
		logic [7:0]         out_dst_route;
		logic [7:0]         out_to_pos;
		logic [7:0]         out_moved_count;
		logic [2:0]         out_orientation;
		logic [15:0]        out_demand_src;
		logic [15:0]        out_demand_to;
	} res_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_ROTATE = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   cand;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_OFFER = 3'b010,
		ST_READ  = 3'b100
	} state_t;

endpackage
`default_nettype wire

FILE: hdl/tkmk_if.sv
`default_nettype none
interface tkmk_item_if;
	logic            valid;
	logic            ready;
	tkmk_pkg::item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tkmk_res_if;
	logic           valid;
	logic           ready;
	tkmk_pkg::res_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/top_k_move_keeper.sv
`default_nettype none
// Keeps the best TOP_K_CAPACITY moves (k_in_use of them, clamped to 1..capacity)
// in a row of cells sorted best first. An offer is inserted as it is accepted: every
// cell compares its gain with the candidate in parallel and either keeps, takes
// the candidate, or takes its left neighbor's entry. Its single result beat is
// loaded from the offer state once the output register is free. A read turns the
// row as a ring, one cell a cycle while the output is not stalled, emitting cell 0
// for each held entry, and returns the list unchanged. Clear, and read of an empty
// list, load their single result beat straight from the idle state. A new item is
// taken only when the block is idle and the output register is free or being drained.
module top_k_move_keeper #(
	parameter int TOP_K_CAPACITY = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	tkmk_item_if.sink                            item,
	tkmk_res_if.source                           res,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [tkmk_pkg::APB_AW-1:0]     paddr,
	input  wire logic [tkmk_pkg::APB_DW-1:0]     pwdata,
	output logic      [tkmk_pkg::APB_DW-1:0]     prdata,
	output logic                                 pready
);

	localparam int HELD_W = $clog2(TOP_K_CAPACITY + 1);
	localparam logic [HELD_W-1:0] CAP_H = HELD_W'(TOP_K_CAPACITY);
	localparam logic [HELD_W-1:0] LAST_CELL = HELD_W'(TOP_K_CAPACITY - 1);

	tkmk_pkg::state_t                 state_q, state_d;
	logic [HELD_W-1:0]                held_q, held_d;
	logic [HELD_W-1:0]                rot_q, rot_d;
	logic [tkmk_pkg::CFG_W-1:0]       k_in_use_q;
	logic                             acc_q, acc_d;
	logic                             out_valid_q;
	tkmk_pkg::res_t                   out_q, res_d;
	logic                             load;

	tkmk_pkg::cell_ctrl_t             cell_ctrl;
	tkmk_pkg::cell_op_t               cell_op;
	tkmk_pkg::entry_t                 cand;
	tkmk_pkg::entry_t                 cell_q [TOP_K_CAPACITY];
	logic [TOP_K_CAPACITY-1:0]        beat;

	logic [tkmk_pkg::CFG_W-1:0]       k_lim;
	logic [HELD_W-1:0]                kk;
	logic [HELD_W-1:0]                held_eff;
	logic                             beat_k;
	logic                             acc;
	logic signed [31:0]               worst;
	logic                             out_free;
	logic                             item_fire;
	logic                             cfg_wr;
	logic                             in_list;

	// ---------------- configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == tkmk_pkg::REG_K_IN_USE) ?
		tkmk_pkg::APB_DW'(k_in_use_q) : '0;

	// ---------------- candidate cells
	assign cand.gain        = item.data.gain;
	assign cand.src_route   = item.data.src_route;
	assign cand.src_pos     = item.data.src_pos;
	assign cand.dst_route   = item.data.dst_route;
	assign cand.to_pos      = item.data.to_pos;
	assign cand.moved_count = item.data.moved_count;
	assign cand.orientation = item.data.orientation;
	assign cand.demand_src  = item.data.demand_src;
	assign cand.demand_to   = item.data.demand_to;
	assign cell_ctrl        = '{op: cell_op, cand: cand};

	for (genvar i = 0; i < TOP_K_CAPACITY; i++) begin : g_cell
		localparam int PREV = (i == 0) ? 0 : i - 1;
		localparam int NEXT = (i + 1) % TOP_K_CAPACITY;
		tkmk_cell u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl),
			.in_held    (held_eff > HELD_W'(i)),
			.prev_beat  ((i == 0) ? 1'b1 : beat[PREV]),
			.prev_entry (cell_q[PREV]),
			.next_entry (cell_q[NEXT]),
			.beat       (beat[i]),
			.entry      (cell_q[i])
		);
	end

	// ---------------- limits and offer decision
	always_comb begin
		if (k_in_use_q == '0) begin
			k_lim = tkmk_pkg::CFG_W'(1);
		end else if (k_in_use_q > tkmk_pkg::CFG_W'(TOP_K_CAPACITY)) begin
			k_lim = tkmk_pkg::CFG_W'(TOP_K_CAPACITY);
		end else begin
			k_lim = k_in_use_q;
		end
		kk       = HELD_W'(k_lim);
		held_eff = (held_q > kk) ? kk : held_q;
		beat_k   = 1'b0;
		worst    = '0;
		for (int i = 0; i < TOP_K_CAPACITY; i++) begin
			if (HELD_W'(i + 1) == kk) beat_k = beat[i];
			if (HELD_W'(i + 1) == held_q) worst = cell_q[i].gain;
		end
		// beats form a prefix, so the candidate lands inside k unless cell k-1 beats it
		acc = !beat_k;
	end

	assign out_free  = !out_valid_q || res.ready;
	assign item.ready = (state_q == tkmk_pkg::ST_IDLE) && out_free;
	assign item_fire = item.valid && item.ready;
	assign in_list   = rot_q < held_q;

	// ---------------- sequencer
	always_comb begin
		state_d = state_q;
		held_d  = held_q;
		rot_d   = rot_q;
		acc_d   = acc_q;
		cell_op = tkmk_pkg::OP_HOLD;
		load    = 1'b0;
		res_d   = '0;
		unique case (state_q)
			tkmk_pkg::ST_IDLE: begin
				if (item_fire) begin
					unique case (item.data.command)
						tkmk_pkg::CMD_OFFER: begin
							cell_op = acc ? tkmk_pkg::OP_INSERT : tkmk_pkg::OP_HOLD;
							held_d  = held_eff + HELD_W'(held_eff < kk);
							acc_d   = acc;
							state_d = tkmk_pkg::ST_OFFER;
						end
						tkmk_pkg::CMD_READ: begin
							if (held_q == '0) begin
								load             = 1'b1;
								res_d.last_entry = 1'b1;
							end else begin
								rot_d   = '0;
								state_d = tkmk_pkg::ST_READ;
							end
						end
						tkmk_pkg::CMD_CLEAR: begin
							held_d           = '0;
							load             = 1'b1;
							res_d.last_entry = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			tkmk_pkg::ST_OFFER: begin
				if (out_free) begin
					load             = 1'b1;
					res_d.accepted   = acc_q;
					res_d.held_count = 5'(held_q);
					res_d.last_entry = 1'b1;
					res_d.out_gain   = worst;
					state_d          = tkmk_pkg::ST_IDLE;
				end
			end
			tkmk_pkg::ST_READ: begin
				// cells past the held count still turn so the ring comes back home
				if (!in_list || out_free) begin
					cell_op = tkmk_pkg::OP_ROTATE;
					if (in_list) begin
						load                  = 1'b1;
						res_d.held_count      = 5'(held_q);
						res_d.last_entry      = (HELD_W'(rot_q + 1'b1) == held_q);
						res_d.out_gain        = cell_q[0].gain;
						res_d.out_src_route   = cell_q[0].src_route;
						res_d.out_src_pos     = cell_q[0].src_pos;
						res_d.out_dst_route   = cell_q[0].dst_route;
						res_d.out_to_pos      = cell_q[0].to_pos;
						res_d.out_moved_count = cell_q[0].moved_count;
						res_d.out_orientation = cell_q[0].orientation;
						res_d.out_demand_src  = cell_q[0].demand_src;
						res_d.out_demand_to   = cell_q[0].demand_to;
					end
					if (rot_q == LAST_CELL) begin
						state_d = tkmk_pkg::ST_IDLE;
					end else begin
						rot_d = HELD_W'(rot_q + 1'b1);
					end
				end
			end
			default: begin
				state_d = tkmk_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tkmk_pkg::ST_IDLE;
			held_q      <= '0;
			rot_q       <= '0;
			out_valid_q <= 1'b0;
			k_in_use_q  <= tkmk_pkg::K_RESET;
		end else begin
			state_q <= state_d;
			held_q  <= held_d;
			rot_q   <= rot_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr && paddr[2] == tkmk_pkg::REG_K_IN_USE) begin
				k_in_use_q <= pwdata[tkmk_pkg::CFG_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_d;
		if (load) begin
			out_q <= res_d;
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	// ---------------- checks
	a_held_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CAP_H)
		else $error("held count above capacity");

	a_offer_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(item_fire && item.data.command == tkmk_pkg::CMD_OFFER) |=>
		(state_q == tkmk_pkg::ST_OFFER && held_q != '0))
		else $error("offer left the list empty or skipped its result");

	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tkmk_pkg::ST_READ) |-> (held_q != '0))
		else $error("ring turn on an empty list");

	a_mid_beat_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.last_entry) |-> (state_q == tkmk_pkg::ST_READ))
		else $error("non-final beat outside a read");

endmodule
`default_nettype wire

FILE: hdl/tkmk_cell.sv
`default_nettype none
module tkmk_cell (
	input  wire logic                 clk,
	input  wire tkmk_pkg::cell_ctrl_t ctrl,
	input  wire logic                 in_held,
	input  wire logic                 prev_beat,
	input  wire tkmk_pkg::entry_t     prev_entry,
	input  wire tkmk_pkg::entry_t     next_entry,
	output logic                      beat,
	output tkmk_pkg::entry_t          entry
);

	tkmk_pkg::entry_t entry_q;

	// held entry with gain >= candidate stays ahead of it (older wins ties)
	assign beat  = in_held && ($signed(entry_q.gain) >= $signed(ctrl.cand.gain));
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			tkmk_pkg::OP_INSERT: begin
				if (!beat) begin
					entry_q <= prev_beat ? ctrl.cand : prev_entry;
				end
			end
			tkmk_pkg::OP_ROTATE: begin
				entry_q <= next_entry;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: dv/top_k_move_keeper_test.sv
`timescale 1ns / 100ps
`default_nettype none
module top_k_move_keeper_test;

	localparam int KEEP_CAP = 4;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [tkmk_pkg::APB_AW-1:0] K_ADDR =
		tkmk_pkg::APB_AW'(4 * int'(tkmk_pkg::REG_K_IN_USE));
	localparam int SETTLE_CYCLES = 8;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [tkmk_pkg::APB_AW-1:0] paddr;
	logic [tkmk_pkg::APB_DW-1:0] pwdata;
	logic [tkmk_pkg::APB_DW-1:0] prdata;
	logic pready;

	tkmk_item_if item_bus();
	tkmk_res_if result_bus();

	top_k_move_keeper #(
		.TOP_K_CAPACITY(KEEP_CAP)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_bus),
		.res(result_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// shadow of the keeper's list and register
	tkmk_pkg::entry_t kept_moves[KEEP_CAP];
	int unsigned kept_count = 0;
	logic signed [31:0] worst_gain = '0;
	logic [tkmk_pkg::CFG_W-1:0] k_shadow = tkmk_pkg::K_RESET;

	tkmk_pkg::res_t awaited_results[$];
	int fail_count = 0;
	int send_idle_pct = 36;
	int stall_pct = 77;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int unsigned k_effective();
		if (k_shadow < 1)
			return 1;
		if (k_shadow > KEEP_CAP)
			return KEEP_CAP;
		return int'(k_shadow);
	endfunction

	function automatic void queue_result(input tkmk_pkg::res_t r);
		awaited_results.insert(awaited_results.size(), r);
	endfunction

	function automatic void predict_keeper_results(input tkmk_pkg::item_t it);
		tkmk_pkg::entry_t cand;
		tkmk_pkg::res_t r;
		int unsigned k;
		int unsigned slot;
		bit took;
		r = '0;
		case (it.command)
			tkmk_pkg::CMD_OFFER: begin
				k = k_effective();
				cand.gain = it.gain;
				cand.src_route = it.src_route;
				cand.src_pos = it.src_pos;
				cand.dst_route = it.dst_route;
				cand.to_pos = it.to_pos;
				cand.moved_count = it.moved_count;
				cand.orientation = it.orientation;
				cand.demand_src = it.demand_src;
				cand.demand_to = it.demand_to;
				// k lowered below what is held: trim the tail first
				if (kept_count > k) begin
					kept_count = k;
					worst_gain = kept_moves[k-1].gain;
				end
				took = 1'b0;
				slot = 0;
				if (kept_count < k) begin
					took = 1'b1;
					slot = kept_count;
					kept_count++;
				end else if ($signed(it.gain) > $signed(kept_moves[kept_count-1].gain)) begin
					took = 1'b1;
					slot = kept_count - 1;
				end
				if (took) begin
					// ties stay behind the older entry
					while (slot > 0 &&
					       $signed(kept_moves[slot-1].gain) < $signed(it.gain)) begin
						kept_moves[slot] = kept_moves[slot-1];
						slot--;
					end
					kept_moves[slot] = cand;
					worst_gain = kept_moves[kept_count-1].gain;
				end
				r.accepted = took;
				r.held_count = 5'(kept_count);
				r.last_entry = 1'b1;
				r.out_gain = worst_gain;
				queue_result(r);
			end
			tkmk_pkg::CMD_READ: begin
				if (kept_count == 0) begin
					r.last_entry = 1'b1;
					queue_result(r);
				end else begin
					for (int i = 0; i < kept_count; i++) begin
						r.accepted = 1'b0;
						r.held_count = 5'(kept_count);
						r.last_entry = (i + 1 == kept_count);
						r.out_gain = kept_moves[i].gain;
						r.out_src_route = kept_moves[i].src_route;
						r.out_src_pos = kept_moves[i].src_pos;
						r.out_dst_route = kept_moves[i].dst_route;
						r.out_to_pos = kept_moves[i].to_pos;
						r.out_moved_count = kept_moves[i].moved_count;
						r.out_orientation = kept_moves[i].orientation;
						r.out_demand_src = kept_moves[i].demand_src;
						r.out_demand_to = kept_moves[i].demand_to;
						queue_result(r);
					end
				end
			end
			tkmk_pkg::CMD_CLEAR: begin
				kept_count = 0;
				worst_gain = '0;
				r.last_entry = 1'b1;
				queue_result(r);
			end
			default: begin
			end
		endcase
	endfunction

	task automatic check_field(input string what, input logic [31:0] want,
	                           input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result_beat(input tkmk_pkg::res_t got);
		tkmk_pkg::res_t want;
		if (awaited_results.size() == 0) begin
			$display("%0t: unexpected result beat, expected none actual %p", $time, got);
			fail_count++;
		end else begin
			want = awaited_results.pop_front();
			check_field("accepted", 32'(want.accepted), 32'(got.accepted));
			check_field("held_count", 32'(want.held_count), 32'(got.held_count));
			check_field("last_entry", 32'(want.last_entry), 32'(got.last_entry));
			check_field("out_gain", want.out_gain, got.out_gain);
			check_field("out_src_route", 32'(want.out_src_route), 32'(got.out_src_route));
			check_field("out_src_pos", 32'(want.out_src_pos), 32'(got.out_src_pos));
			check_field("out_dst_route", 32'(want.out_dst_route), 32'(got.out_dst_route));
			check_field("out_to_pos", 32'(want.out_to_pos), 32'(got.out_to_pos));
			check_field("out_moved_count", 32'(want.out_moved_count),
			            32'(got.out_moved_count));
			check_field("out_orientation", 32'(want.out_orientation),
			            32'(got.out_orientation));
			check_field("out_demand_src", 32'(want.out_demand_src),
			            32'(got.out_demand_src));
			check_field("out_demand_to", 32'(want.out_demand_to), 32'(got.out_demand_to));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
			check_result_beat(result_bus.data);
		result_bus.ready <= ($urandom_range(99) >= stall_pct);
	end

	// valid stays up after a beat; the next call either replaces the data or drops it
	task automatic send_item(input tkmk_pkg::item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.data <= it;
		do
			@(posedge clk);
		while (item_bus.ready !== 1'b1);
		predict_keeper_results(it);
	endtask

	task automatic wait_until_idle();
		item_bus.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_k(input logic [tkmk_pkg::CFG_W-1:0] value);
		wait_until_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= K_ADDR;
		pwdata <= tkmk_pkg::APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		k_shadow = value;
	endtask

	function automatic tkmk_pkg::item_t move_item(input logic [1:0] cmd,
	                                              input logic signed [31:0] g,
	                                              input logic [7:0] tag,
	                                              input logic [2:0] orient);
		tkmk_pkg::item_t it;
		it.command = cmd;
		it.gain = g;
		it.src_route = tag;
		it.src_pos = tag;
		it.dst_route = tag;
		it.to_pos = tag;
		it.moved_count = tag;
		it.orientation = orient;
		it.demand_src = {tag, tag};
		it.demand_to = {tag, tag};
		return it;
	endfunction

	function automatic tkmk_pkg::item_t random_item();
		tkmk_pkg::item_t it;
		int unsigned pick;
		int signed whole;
		it.src_route = 8'($urandom());
		it.src_pos = 8'($urandom());
		it.dst_route = 8'($urandom());
		it.to_pos = 8'($urandom());
		it.moved_count = 8'($urandom());
		it.orientation = 3'($urandom());
		it.demand_src = 16'($urandom());
		it.demand_to = 16'($urandom());
		pick = $urandom_range(99);
		if (pick < 70)
			it.command = tkmk_pkg::CMD_OFFER;
		else if (pick < 86)
			it.command = tkmk_pkg::CMD_READ;
		else if (pick < 96)
			it.command = tkmk_pkg::CMD_CLEAR;
		else
			it.command = CMD_UNUSED;
		// small whole numbers give plenty of ties
		pick = $urandom_range(9);
		if (pick < 4) begin
			whole = int'($urandom_range(8)) - 4;
			it.gain = whole * 65536;
		end else if (pick < 8) begin
			it.gain = $urandom();
		end else begin
			case ($urandom_range(3))
				0: it.gain = 32'sh7fff_ffff;
				1: it.gain = 32'sh8000_0000;
				2: it.gain = 32'sh0000_0000;
				default: it.gain = 32'shffff_ffff;
			endcase
		end
		return it;
	endfunction

	task automatic test_empty_list();
		send_item(move_item(tkmk_pkg::CMD_READ, 0, 8'h00, 3'd0));
		send_item(move_item(tkmk_pkg::CMD_CLEAR, 0, 8'h00, 3'd0));
	endtask

	task automatic test_default_k_order();
		send_item(move_item(tkmk_pkg::CMD_OFFER, 32'sh0005_0000, 8'h11, 3'd1));
		send_item(move_item(tkmk_pkg::CMD_OFFER, 32'sh0003_0000, 8'h22, 3'd2));
		send_item(move_item(tkmk_pkg::CMD_OFFER, 32'sh0005_0000, 8'h33, 3'd3));
		// full: lower and equal to worst are refused, a better one bumps the worst
		send_item(move_item(tkmk_pkg::CMD_OFFER, 32'sh0001_0000, 8'h44, 3'd4));
		send_item(move_item(tkmk_pkg::CMD_OFFER, 32'sh0003_0000, 8'h55, 3'd0));
		send_item(move_item(tkmk_pkg::CMD_OFFER, 32'sh0007_0000, 8'h66, 3'd1));
		send_item(move_item(CMD_UNUSED, 32'sh0009_0000, 8'h77, 3'd2));
		send_item(move_item(tkmk_pkg::CMD_READ, 0, 8'h00, 3'd0));
	endtask

	task automatic test_field_extremes();
		send_item(move_item(tkmk_pkg::CMD_CLEAR, 0, 8'h00, 3'd0));
		send_item(move_item(tkmk_pkg::CMD_OFFER, 32'sh7fff_ffff, 8'hff, 3'd7));
		send_item(move_item(tkmk_pkg::CMD_OFFER, 32'sh8000_0000, 8'h00, 3'd0));
		send_item(move_item(tkmk_pkg::CMD_OFFER, 32'sh0000_0000, 8'ha5, 3'd5));
		send_item(move_item(tkmk_pkg::CMD_OFFER, 32'shffff_ffff, 8'h5a, 3'd6));
		send_item(move_item(tkmk_pkg::CMD_READ, 0, 8'h00, 3'd0));
	endtask

	task automatic test_k_register();
		write_k(5'd4);
		send_item(move_item(tkmk_pkg::CMD_OFFER, 32'sh0000_8000, 8'h3c, 3'd3));
		// shrinking k: read still shows all, next offer trims
		write_k(5'd1);
		send_item(move_item(tkmk_pkg::CMD_READ, 0, 8'h00, 3'd0));
		send_item(move_item(tkmk_pkg::CMD_OFFER, 32'sh8000_0001, 8'hc3, 3'd4));
		write_k(5'd0);
		send_item(move_item(tkmk_pkg::CMD_OFFER, 32'sh7fff_ffff, 8'h96, 3'd2));
		write_k(5'd31);
		send_item(move_item(tkmk_pkg::CMD_OFFER, 32'sh0002_0000, 8'h69, 3'd1));
		write_k(5'd16);
		send_item(move_item(tkmk_pkg::CMD_READ, 0, 8'h00, 3'd0));
	endtask

	task automatic test_random_traffic();
		tkmk_pkg::item_t it;
		int sent;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 36; stall_pct = 77; end
				1: begin send_idle_pct = 77; stall_pct = 36; end
				default: begin send_idle_pct = 0; stall_pct = 0; end
			endcase
			for (int part = 0; part < 3; part++) begin
				if ($urandom_range(1))
					write_k(5'($urandom_range(31)));
				else
					write_k(5'($urandom_range(1, KEEP_CAP)));
				sent = 0;
				while (sent < 23) begin
					it = random_item();
					send_item(it);
					if (it.command != CMD_UNUSED)
						sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_bus.valid = 1'b0;
		item_bus.data = '0;
		result_bus.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_default_k_order();
		test_field_extremes();
		test_k_register();
		test_random_traffic();
		wait_until_idle();
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire

FILE: sim.f
hdl/tkmk_pkg.sv
hdl/tkmk_if.sv
hdl/tkmk_cell.sv
hdl/top_k_move_keeper.sv
dv/top_k_move_keeper_test.sv
